// File: hdl/uer_pkg.sv
`default_nettype none
package uer_pkg;

   localparam int SENSORS = 4;
   localparam int ECHO_W = 4;
   localparam int ELAPSED_W = 17;
   localparam int CM_W = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [3:0] SENSOR_LIMIT = 4'(SENSORS);
   localparam logic [3:0] ECHO_LIMIT = 4'(ECHO_W);

   localparam logic [CSR_INDEX_W-1:0] REG_TIMEOUT = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_TICKS_PER_CM = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_MIN_CM = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_CM = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_PRE_LOW = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_TRIGGER = 3'd5;

   localparam logic [15:0] RST_TIMEOUT = 16'd30000;
   localparam logic [7:0] RST_TICKS_PER_CM = 8'd58;
   localparam logic [9:0] RST_MIN_CM = 10'd2;
   localparam logic [9:0] RST_MAX_CM = 10'd400;
   localparam logic [7:0] RST_PRE_LOW = 8'd2;
   localparam logic [7:0] RST_TRIGGER = 8'd10;

   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_START = 1'b1;

   typedef enum logic [4:0] {
      PH_IDLE   = 5'b00001,
      PH_PRELOW = 5'b00010,
      PH_TRIG   = 5'b00100,
      PH_RISE   = 5'b01000,
      PH_HIGH   = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [15:0] timeout_ticks;
      logic [7:0] ticks_per_cm;
      logic [9:0] min_cm;
      logic [9:0] max_cm;
      logic [7:0] pre_low_ticks;
      logic [7:0] trigger_ticks;
   } cfg_type;

   typedef struct packed {
      logic req_type;
      logic [2:0] sensor_id;
      logic [3:0] echo_levels;
   } req_word_type;

   typedef struct packed {
      logic [3:0] trig_levels;
      logic done_res;
      logic [9:0] distance_cm;
      logic out_of_range;
      logic busy_res;
   } rsp_word_type;

endpackage
`default_nettype wire

// File: hdl/uer_csr.sv
`default_nettype none
module uer_csr (
   input wire logic clock,
   input wire logic reset,
   input wire logic csr_valid,
   output logic csr_ready,
   input wire logic [uer_pkg::CSR_INDEX_W-1:0] csr_index,
   input wire logic [uer_pkg::CSR_DATA_W-1:0] csr_data,
   output uer_pkg::cfg_type cfg
);
   import uer_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_TIMEOUT: cfg_in.timeout_ticks = csr_data;
            REG_TICKS_PER_CM: cfg_in.ticks_per_cm = csr_data[7:0];
            REG_MIN_CM: cfg_in.min_cm = csr_data[9:0];
            REG_MAX_CM: cfg_in.max_cm = csr_data[9:0];
            REG_PRE_LOW: cfg_in.pre_low_ticks = csr_data[7:0];
            REG_TRIGGER: cfg_in.trigger_ticks = csr_data[7:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ticks <= RST_TIMEOUT;
         cfg_ff.ticks_per_cm <= RST_TICKS_PER_CM;
         cfg_ff.min_cm <= RST_MIN_CM;
         cfg_ff.max_cm <= RST_MAX_CM;
         cfg_ff.pre_low_ticks <= RST_PRE_LOW;
         cfg_ff.trigger_ticks <= RST_TRIGGER;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

// File: hdl/uer_seq.sv
`default_nettype none
module uer_seq (
   input wire logic clock,
   input wire logic reset,
   input wire logic accept,
   input wire uer_pkg::req_word_type req_word,
   input wire uer_pkg::cfg_type cfg,
   output uer_pkg::rsp_word_type rsp_word
);
   import uer_pkg::*;

   phase_type phase_ff, phase_in;
   logic [2:0] active_ff, active_in;
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic [7:0] sub_ff, sub_in;
   logic [CM_W-1:0] cm_ff, cm_in;

   logic level;
   logic [ELAPSED_W-1:0] elapsed_inc;
   logic [7:0] sub_inc;
   logic cm_bad;
   logic finish;
   logic fail;

   always_comb begin
      level = 1'b0;
      if ({1'b0, active_ff} < ECHO_LIMIT) begin
         level = req_word.echo_levels[active_ff[1:0]];
      end
      elapsed_inc = elapsed_ff + 1'b1;
      sub_inc = sub_ff + 1'b1;
      cm_bad = (cm_ff < CM_W'(cfg.min_cm)) || (cm_ff > CM_W'(cfg.max_cm));

      phase_in = phase_ff;
      active_in = active_ff;
      elapsed_in = elapsed_ff;
      sub_in = sub_ff;
      cm_in = cm_ff;
      finish = 1'b0;
      fail = 1'b0;

      if (req_word.req_type == REQ_START) begin
         if (phase_ff == PH_IDLE) begin
            if ({1'b0, req_word.sensor_id} >= SENSOR_LIMIT) begin
               finish = 1'b1;
               fail = 1'b1;
            end else begin
               active_in = req_word.sensor_id;
               elapsed_in = '0;
               sub_in = '0;
               cm_in = '0;
               phase_in = (cfg.pre_low_ticks == 8'd0) ? PH_TRIG : PH_PRELOW;
            end
         end
      end else begin
         case (phase_ff)
            PH_IDLE: begin
               phase_in = PH_IDLE;
            end
            PH_PRELOW: begin
               elapsed_in = elapsed_inc;
               if (elapsed_inc >= ELAPSED_W'(cfg.pre_low_ticks)) begin
                  phase_in = PH_TRIG;
                  elapsed_in = '0;
               end
            end
            PH_TRIG: begin
               elapsed_in = elapsed_inc;
               if (elapsed_inc >= ELAPSED_W'(cfg.trigger_ticks)) begin
                  phase_in = PH_RISE;
                  elapsed_in = '0;
               end
            end
            PH_RISE: begin
               if (level) begin
                  phase_in = PH_HIGH;
                  elapsed_in = '0;
                  sub_in = '0;
                  cm_in = '0;
               end else begin
                  elapsed_in = elapsed_inc;
                  if (elapsed_inc > ELAPSED_W'(cfg.timeout_ticks)) begin
                     finish = 1'b1;
                     fail = 1'b1;
                  end
               end
            end
            PH_HIGH: begin
               if (!level) begin
                  finish = 1'b1;
                  fail = cm_bad;
               end else begin
                  elapsed_in = elapsed_inc;
                  sub_in = sub_inc;
                  if (sub_inc == cfg.ticks_per_cm) begin
                     sub_in = '0;
                     if (cm_ff != {CM_W{1'b1}}) begin
                        cm_in = cm_ff + 1'b1;
                     end
                  end
                  if (elapsed_inc > ELAPSED_W'(cfg.timeout_ticks)) begin
                     finish = 1'b1;
                     fail = 1'b1;
                  end
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end

      if (finish) begin
         phase_in = PH_IDLE;
         elapsed_in = '0;
      end

      rsp_word.done_res = finish;
      rsp_word.out_of_range = finish & fail;
      rsp_word.distance_cm = (finish && !fail) ? cm_ff[9:0] : 10'd0;
      rsp_word.trig_levels = '0;
      if ((phase_in == PH_TRIG) && ({1'b0, active_in} < ECHO_LIMIT)) begin
         rsp_word.trig_levels = 4'd1 << active_in[1:0];
      end
      rsp_word.busy_res = (phase_in != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         active_ff <= '0;
         elapsed_ff <= '0;
         sub_ff <= '0;
         cm_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         active_ff <= active_in;
         elapsed_ff <= elapsed_in;
         sub_ff <= sub_in;
         cm_ff <= cm_in;
      end
   end

endmodule
`default_nettype wire

// File: hdl/uer_skid.sv
`default_nettype none
module uer_skid (
   input wire logic clock,
   input wire logic reset,
   input wire logic in_valid,
   output logic in_stall,
   input wire uer_pkg::rsp_word_type in_word,
   output logic out_valid,
   input wire logic out_stall,
   output uer_pkg::rsp_word_type out_word
);
   import uer_pkg::*;

   logic main_valid_ff, main_valid_in;
   logic skid_valid_ff, skid_valid_in;
   rsp_word_type main_word_ff, main_word_in;
   rsp_word_type skid_word_ff, skid_word_in;
   logic take;
   logic load;

   assign take = main_valid_ff & ~out_stall;
   assign load = in_valid & ~skid_valid_ff;
   assign in_stall = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_word = main_word_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_word_in = main_word_ff;
      skid_word_in = skid_word_ff;
      if (skid_valid_ff) begin
         if (take) begin
            main_word_in = skid_word_ff;
            skid_valid_in = 1'b0;
         end
      end else if (load) begin
         if (!main_valid_ff || take) begin
            main_word_in = in_word;
            main_valid_in = 1'b1;
         end else begin
            skid_word_in = in_word;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_word_ff <= main_word_in;
      skid_word_ff <= skid_word_in;
   end

endmodule
`default_nettype wire

// File: hdl/ultrasonic_echo_ranger.sv
`default_nettype none
// Ultrasonic echo ranger: every input word is either a 1 us tick carrying the
// sampled echo lines or a start request naming a sensor, and every accepted
// word yields exactly one result word (trigger drive, done, distance, out of
// range, busy). One word is accepted per clock cycle while req_stall is low;
// its result goes to the output register, or to the skid register if held.
// The sequencer state updates once per word, and this two-entry buffer lets
// input continue while one result waits; req_stall rises only when both
// entries are occupied. Configuration registers are written through the
// csr_ port, always ready, and take effect on the next word.
module ultrasonic_echo_ranger (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire uer_pkg::req_word_type req_word,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output uer_pkg::rsp_word_type rsp_word,
   input wire logic csr_valid,
   output logic csr_ready,
   input wire logic [uer_pkg::CSR_INDEX_W-1:0] csr_index,
   input wire logic [uer_pkg::CSR_DATA_W-1:0] csr_data
);
   import uer_pkg::*;

   cfg_type cfg;
   rsp_word_type next_word;
   logic accept;

   assign accept = req_valid & ~req_stall;

   uer_csr u_csr (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .cfg(cfg)
   );

   uer_seq u_seq (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .req_word(req_word),
      .cfg(cfg),
      .rsp_word(next_word)
   );

   uer_skid u_skid (
      .clock(clock),
      .reset(reset),
      .in_valid(req_valid),
      .in_stall(req_stall),
      .in_word(next_word),
      .out_valid(rsp_valid),
      .out_stall(rsp_stall),
      .out_word(rsp_word)
   );

endmodule
`default_nettype wire
